[hdl/sdr_pkg.sv]
// shared widths, scale table and controller/datapath interface types
package sdr_pkg;

    localparam int VALUE_W        = 30;
    localparam int COUNT_W        = 4;
    localparam int BOUND_W        = 32;
    localparam int PROD_W         = VALUE_W + BOUND_W;
    localparam int CMP_W          = PROD_W + 2;
    localparam int S_TDATA_W      = 40;
    localparam int M_TDATA_W      = 32;
    localparam int DEF_MAX_DIGITS = 9;
    localparam logic [VALUE_W-1:0] SCALE_MAX = 30'd1000000000;

    typedef struct packed {
        logic load;
        logic mediant;
        logic multiply;
        logic update;
        logic set_one;
        logic emit;
    } sdr_cmd_t;

    typedef struct packed {
        logic trivial;
        logic hit;
    } sdr_status_t;

    // ten to the power of a digit count
    function automatic logic [VALUE_W-1:0] pow10(input logic [COUNT_W-1:0] n);
        logic [VALUE_W-1:0] r;
        case (n)
            4'd0:    r = 30'd1;
            4'd1:    r = 30'd10;
            4'd2:    r = 30'd100;
            4'd3:    r = 30'd1000;
            4'd4:    r = 30'd10000;
            4'd5:    r = 30'd100000;
            4'd6:    r = 30'd1000000;
            4'd7:    r = 30'd10000000;
            4'd8:    r = 30'd100000000;
            default: r = SCALE_MAX;
        endcase
        return r;
    endfunction

endpackage

[hdl/smallest_denominator_for_rounded_decimal_unit.sv]
// top level: smallest denominator of a fraction rounding to a given decimal
//
// channel  dir  ports                      word
// s_       in   s_tvalid s_tready s_tdata  decimal_value, digit_count
// m_       out  m_tvalid m_tready m_tdata  smallest_denominator
//
// one word is worked at a time; each walk step is a mediant add, then a
// 30x32 multiply pair, then a 64-bit compare and bound update; a word walks
// up to about the scale (10^9) mediants before the next word is accepted
// words whose value is 0 or at/above the scale skip the walk and set the answer to 1
// aresetn is synchronous, active low, and clears only control state
// the result sits in an output register, so a new word is taken while it waits
module smallest_denominator_for_rounded_decimal_unit
    import sdr_pkg::*;
#(
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // decimal_value[29:0], digit_count[33:30], zeros
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // smallest_denominator[29:0], zeros
);

    sdr_cmd_t           cmd;
    sdr_status_t        status;
    logic [VALUE_W-1:0] denominator;

    sdr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sdr_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .aclk            (aclk),
        .in_value        (s_tdata[VALUE_W-1:0]),
        .in_count        (s_tdata[VALUE_W+COUNT_W-1:VALUE_W]),
        .cmd             (cmd),
        .status          (status),
        .out_denominator (denominator)
    );

    // pad result word to whole bytes
    assign m_tdata = M_TDATA_W'(denominator);

    // no new word taken in the cycle after one is accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a walk is in progress");

    // a denominator is never zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[VALUE_W-1:0] != '0))
        else $error("zero denominator");

    // the answer never exceeds the largest scale
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[VALUE_W-1:0] <= SCALE_MAX))
        else $error("denominator above the largest scale");

endmodule

[hdl/sdr_ctrl.sv]
// sequencer for the mediant walk and the output handshake
module sdr_ctrl
    import sdr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  sdr_status_t status,
    output sdr_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MED  = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_CMP  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MED;
                end
            end
            ST_MED: begin
                if (status.trivial) begin
                    cmd.set_one = 1'b1;
                    state_next  = ST_DONE;
                end else begin
                    cmd.mediant = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.multiply = 1'b1;
                state_next   = ST_CMP;
            end
            ST_CMP: begin
                cmd.update = 1'b1;
                state_next = status.hit ? ST_DONE : ST_MED;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.emit      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

[hdl/sdr_datapath.sv]
// bounds, mediant, products, rounding test and result register
module sdr_datapath
    import sdr_pkg::*;
#(
    parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
    input  logic                aclk,
    input  logic [VALUE_W-1:0]  in_value,
    input  logic [COUNT_W-1:0]  in_count,
    input  sdr_cmd_t            cmd,
    output sdr_status_t         status,
    output logic [VALUE_W-1:0]  out_denominator
);

    logic [VALUE_W-1:0] v_reg, s_reg, ans_reg, out_reg;
    logic [BOUND_W-1:0] a_reg, b_reg, c_reg, d_reg, p_reg, q_reg;
    logic [PROD_W-1:0]  sp_reg, vq_reg, sp_next, vq_next;
    logic [COUNT_W-1:0] n_clamp;
    logic [VALUE_W-1:0] scale, v_clamp;
    logic [CMP_W-1:0]   sp2, vq2, q_ext;
    logic               in_lo, in_hi;

    // clamp digit count and value
    assign n_clamp = (in_count > COUNT_W'(MAX_DIGITS)) ? COUNT_W'(MAX_DIGITS) : in_count;
    assign scale   = pow10(n_clamp);
    assign v_clamp = (in_value > scale) ? scale : in_value;

    assign sp_next = s_reg * p_reg;
    assign vq_next = v_reg * q_reg;

    // p/q in [(v - 1/2)/s, (v + 1/2)/s)
    assign sp2   = {1'b0, sp_reg, 1'b0};
    assign vq2   = {1'b0, vq_reg, 1'b0};
    assign q_ext = CMP_W'(q_reg);
    assign in_lo = (sp2 + q_ext) >= vq2;
    assign in_hi = sp2 < (vq2 + q_ext);

    assign status.hit     = in_lo && in_hi;
    assign status.trivial = (v_reg == '0) || (v_reg == s_reg);
    assign out_denominator = out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            v_reg <= v_clamp;
            s_reg <= scale;
            a_reg <= BOUND_W'(0);
            b_reg <= BOUND_W'(1);
            c_reg <= BOUND_W'(1);
            d_reg <= BOUND_W'(1);
        end
        if (cmd.mediant) begin
            p_reg <= a_reg + c_reg;
            q_reg <= b_reg + d_reg;
        end
        if (cmd.multiply) begin
            sp_reg <= sp_next;
            vq_reg <= vq_next;
        end
        if (cmd.update) begin
            if (in_lo && in_hi) begin
                ans_reg <= q_reg[VALUE_W-1:0];
            end else if (!in_lo) begin
                a_reg <= p_reg;
                b_reg <= q_reg;
            end else begin
                c_reg <= p_reg;
                d_reg <= q_reg;
            end
        end
        if (cmd.set_one) begin
            ans_reg <= VALUE_W'(1);
        end
        if (cmd.emit) begin
            out_reg <= ans_reg;
        end
    end

endmodule

[sim/smallest_denominator_for_rounded_decimal_unit_tb.sv]
// testbench: directed and random decimals against a tree-walk predictor of the smallest denominator
`timescale 1ns / 100ps

module smallest_denominator_for_rounded_decimal_unit_tb;
    import sdr_pkg::*;

    // the block walks the mediants one by one, so words are kept to short walks
    localparam int unsigned MAX_WALK    = 1500;
    // covers ~125 words, each walking up to MAX_WALK mediants, plus receiver stalls
    localparam int unsigned CYCLE_LIMIT = 4000000;
    localparam int          DRAIN_WAIT  = 16;
    localparam int          REPORT_MAX  = 10;

    typedef struct packed {
        logic [VALUE_W-1:0] denom;
        logic [63:0]        mediants;
    } walk_result_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic [VALUE_W-1:0] denom;
    } denom_expect_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // decimal_value[29:0], digit_count[33:30], zeros
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // smallest_denominator[29:0], zeros

    denom_expect_t pending_denoms[$];
    int unsigned   send_idle_pct;
    int unsigned   recv_idle_pct;
    int unsigned   words_sent;
    int unsigned   results_checked = 0;
    int unsigned   mismatch_count  = 0;
    int unsigned   cycle_count     = 0;

    smallest_denominator_for_rounded_decimal_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // half-up rounding test: p/q inside [(v - 1/2)/s, (v + 1/2)/s)
    function automatic bit rounds_to_decimal(input logic [63:0] p, input logic [63:0] q,
                                             input logic [63:0] v, input logic [63:0] s);
        return (2 * s * p + q >= 2 * v * q) && (2 * s * p < (2 * v + 1) * q);
    endfunction

    // stern-brocot descent, taking each run of same-side mediants in one stride;
    // also counts the mediants the block visits one by one
    function automatic walk_result_t walk_tree(input logic [VALUE_W-1:0] value,
                                               input logic [COUNT_W-1:0] count);
        logic [63:0]  s, v, a, b, c, d, sa, sb, j1, jt, ta, tb;
        logic [63:0]  digits;
        walk_result_t r;
        bit           done;
        s      = 1;
        digits = (count > DEF_MAX_DIGITS) ? DEF_MAX_DIGITS : count;
        for (int i = 0; i < digits; i++) s = s * 10;
        v = (value > s) ? s : value;
        a = 0; b = 1; c = 1; d = 1;
        r.denom    = '0;
        r.mediants = '0;
        done       = rounds_to_decimal(0, 1, v, s) || rounds_to_decimal(1, 1, v, s);
        if (done) r.denom = VALUE_W'(1);
        while (!done) begin
            if (v * (b + d) < s * (a + c)) begin
                // mediants fall toward the left bound
                sa = (2 * v + 1) * b - 2 * s * a;
                sb = 2 * s * c - (2 * v + 1) * d;
                j1 = sb / sa + 1;
                ta = v * b - s * a;
                tb = s * c - v * d;
                jt = (tb + ta - 1) / ta;
                if (j1 < jt) begin
                    r.mediants += j1;
                    r.denom     = VALUE_W'(d + j1 * b);
                    done        = 1'b1;
                end else begin
                    r.mediants += jt;
                    {c, d, a, b} = {c + (jt - 1) * a, d + (jt - 1) * b, c + jt * a, d + jt * b};
                    if (rounds_to_decimal(a, b, v, s)) begin
                        r.denom = VALUE_W'(b);
                        done    = 1'b1;
                    end
                end
            end else begin
                // mediants rise toward the right bound
                sa = 2 * s * c + d - 2 * v * d;
                sb = 2 * v * b - (2 * s * a + b);
                j1 = (sb + sa - 1) / sa;
                ta = s * c - v * d;
                tb = v * b - s * a;
                jt = tb / ta + 1;
                if (j1 < jt) begin
                    r.mediants += j1;
                    r.denom     = VALUE_W'(b + j1 * d);
                    done        = 1'b1;
                end else begin
                    r.mediants += jt;
                    {a, b, c, d} = {a + (jt - 1) * c, b + (jt - 1) * d, a + jt * c, b + jt * d};
                    if (rounds_to_decimal(c, d, v, s)) begin
                        r.denom = VALUE_W'(d);
                        done    = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    // present one word, with random idle cycles first, and queue its denominator on acceptance
    task automatic send_word(input logic [VALUE_W-1:0] value, input logic [COUNT_W-1:0] count);
        denom_expect_t e;
        walk_result_t  w;
        w       = walk_tree(value, count);
        e.value = value;
        e.count = count;
        e.denom = w.denom;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - VALUE_W - COUNT_W){1'b0}}, count, value};
        do @(posedge aclk); while (!s_tready);
        pending_denoms = {pending_denoms, e};
        words_sent++;
    endtask

    // receiver: random stall pattern and in-order check of each result word
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (pending_denoms.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result word: denominator %0d", m_tdata[VALUE_W-1:0]);
            end else begin
                denom_expect_t e;
                e = pending_denoms.pop_front();
                results_checked++;
                if (m_tdata !== {{(M_TDATA_W - VALUE_W){1'b0}}, e.denom}) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("mismatch: value %0d digits %0d expected %0d got %0d",
                                 e.value, e.count, e.denom, m_tdata);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_denoms.size());
            $display("smallest_denominator_for_rounded_decimal_unit test failed");
            $finish;
        end
    end

    // zero value, value at or above the scale, digit count zero or clamped
    task automatic test_trivial_decimals();
        send_word(30'd0, 4'd1);
        send_word(30'd0, 4'd9);
        send_word(30'd0, 4'd0);
        send_word(30'd1, 4'd0);
        send_word(30'd10, 4'd1);
        send_word(30'd12345, 4'd2);
        send_word(SCALE_MAX, 4'd9);
        send_word({VALUE_W{1'b1}}, 4'd9);
        send_word({VALUE_W{1'b1}}, 4'd15);
        send_word(30'd500000000, 4'd12);
    endtask

    // every nonzero one-digit decimal
    task automatic test_one_digit();
        for (int v = 1; v <= 9; v++) send_word(VALUE_W'(v), 4'd1);
    endtask

    // simple fractions and the long edge walks that stay affordable
    task automatic test_known_fractions();
        send_word(30'd333333333, 4'd9);
        send_word(30'd142857143, 4'd9);
        send_word(30'd99, 4'd2);
        send_word(30'd999, 4'd3);
        send_word(30'd1, 4'd3);
    endtask

    // mostly in-range decimals, some raw field noise and some near the ends of the range
    task automatic test_random_decimals(input int unsigned words);
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] count;
        logic [63:0]        scale;
        int unsigned        pick;
        walk_result_t       w;
        for (int k = 0; k < words; k++) begin
            do begin
                pick = $urandom_range(99);
                if (pick < 15) begin
                    value = VALUE_W'($urandom());
                    count = COUNT_W'($urandom());
                end else begin
                    count = COUNT_W'($urandom_range(9, 1));
                    scale = 1;
                    for (int i = 0; i < count; i++) scale = scale * 10;
                    if (pick < 30) begin
                        // close to zero or to one
                        value = VALUE_W'($urandom_range(3));
                        if ($urandom_range(1)) value = VALUE_W'(scale - 1 - value);
                    end else begin
                        value = VALUE_W'($urandom() % scale);
                    end
                end
                w = walk_tree(value, count);
            end while (w.mediants > MAX_WALK);
            send_word(value, count);
        end
    endtask

    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        send_idle_pct   = 20;
        recv_idle_pct   = 67;
        words_sent      = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // phase one: light sender gaps, heavy receiver stalls
        test_trivial_decimals();
        test_one_digit();
        test_known_fractions();
        test_random_decimals(35);

        // phase two: the other way round
        send_idle_pct = 67;
        recv_idle_pct = 20;
        test_random_decimals(35);

        // phase three: back to back
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_decimals(30);
        s_tvalid <= 1'b0;

        while (pending_denoms.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("sent %0d decimal words (trivial, one-digit, known fractions, random)",
                 words_sent);
        $display("checked %0d denominators in %0d cycles, %0d mismatches",
                 results_checked, cycle_count, mismatch_count);
        if (mismatch_count == 0 && pending_denoms.size() == 0) begin
            $display("smallest_denominator_for_rounded_decimal_unit test passed");
        end else begin
            $display("smallest_denominator_for_rounded_decimal_unit test failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/sdr_pkg.sv
hdl/sdr_ctrl.sv
hdl/sdr_datapath.sv
hdl/smallest_denominator_for_rounded_decimal_unit.sv
sim/smallest_denominator_for_rounded_decimal_unit_tb.sv
